### src/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multitouch slot tracker
// Slot count, field widths, event codes, register indexes and the structs
// that run between the top level and the row of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

   // Slot row size
   localparam int SLOT_COUNT = 8;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Field widths
   localparam int FINGER_W   = 32;
   localparam int PANEL_X_W  = 11;
   localparam int PANEL_Y_W  = 10;
   localparam int RENDER_W   = 11;
   localparam int POS_W      = 19;
   localparam int EVENT_W    = 2;
   localparam int RSP_SLOT_W = 3;
   localparam int RPT_CNT_W  = 4;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_START = 2'd0;
   localparam logic [EVENT_W-1:0] EV_MOVE  = 2'd1;
   localparam logic [EVENT_W-1:0] EV_END   = 2'd2;

   // Input word modes
   localparam logic MODE_REPORT = 1'b0;
   localparam logic MODE_EOF    = 1'b1;

   // Register indexes
   localparam logic CSR_RENDER_WIDTH  = 1'b0;
   localparam logic CSR_RENDER_HEIGHT = 1'b1;

   // Register reset values and frame limit
   localparam logic [RENDER_W-1:0]  RENDER_WIDTH_RST  = 11'd1280;
   localparam logic [RENDER_W-1:0]  RENDER_HEIGHT_RST = 11'd720;
   localparam logic [RPT_CNT_W-1:0] MAX_REPORTS       = 4'd8;
   localparam logic [POS_W-1:0]     POS_MAX           = 19'h7FFFF;

   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;
   typedef logic [RSP_SLOT_W-1:0] rsp_slot_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic                report;
      logic                eof_mark;
      logic                walk;
      logic [FINGER_W-1:0] finger;
      pos_type             x;
      pos_type             y;
   } cell_cmd_type;

   // Priority chain handed from cell to cell
   typedef struct packed {
      logic         hit;
      slot_idx_type hit_idx;
      logic         moved;
      logic         free;
      slot_idx_type free_idx;
      logic         pend;
      logic         pend2;
      slot_idx_type pend_idx;
      pos_type      pend_x;
      pos_type      pend_y;
   } chain_type;

endpackage

`default_nettype wire

### src/mst_scale.sv
// ----------------------------------------------------------------------------
// mst_scale: panel to render coordinate scaler
// Three-stage pipeline: panel times render size, multiply by a reciprocal,
// then one correction step and saturation. x = floor(px*rw/5),
// y = floor(py*rh*16/45), both in 1/256 render pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_scale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [mst_pkg::PANEL_X_W-1:0] panel_x,
   input  wire logic [mst_pkg::PANEL_Y_W-1:0] panel_y,
   input  wire logic [mst_pkg::RENDER_W-1:0]  render_w,
   input  wire logic [mst_pkg::RENDER_W-1:0]  render_h,
   output logic                               done,
   output mst_pkg::pos_type                   pos_x,
   output mst_pkg::pos_type                   pos_y
);

   // floor(2^24/5) and floor(2^30/45): quotient estimate is low by at most one
   localparam logic [21:0] RECIP5  = 22'd3355443;
   localparam logic [24:0] RECIP45 = 25'd23860929;

   logic        v1_ff, v2_ff, done_ff;
   logic [21:0] prod_x_ff;
   logic [20:0] prod_y_ff;
   logic [21:0] num_x_ff;
   logic [24:0] num_y_ff;
   logic [19:0] qx0_ff, qy0_ff;
   logic [43:0] recip_x;
   logic [49:0] recip_y;
   logic [22:0] x_times5, rem_x;
   logic [25:0] y_times45, rem_y;
   logic [20:0] qx, qy;
   mst_pkg::pos_type pos_x_in, pos_y_in;
   mst_pkg::pos_type pos_x_ff, pos_y_ff;

   // Advance the stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= go;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   // Stage one: raw products
   always_ff @(posedge clock) begin
      if (go) begin
         prod_x_ff <= 22'(panel_x) * 22'(render_w);
         prod_y_ff <= 21'(panel_y) * 21'(render_h);
      end
   end

   // Stage two: multiply by reciprocal, keep numerators for the correction
   assign recip_x = 44'(prod_x_ff) * 44'(RECIP5);
   assign recip_y = 50'({prod_y_ff, 4'b0000}) * 50'(RECIP45);

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         num_x_ff <= prod_x_ff;
         num_y_ff <= {prod_y_ff, 4'b0000};
         qx0_ff   <= recip_x[43:24];
         qy0_ff   <= recip_y[49:30];
      end
   end

   // Stage three: one correction step, then saturate
   always_comb begin
      x_times5  = 23'({qx0_ff, 2'b00}) + 23'(qx0_ff);
      rem_x     = 23'(num_x_ff) - x_times5;
      qx        = 21'(qx0_ff) + 21'(rem_x >= 23'd5);
      y_times45 = 26'({qy0_ff, 5'b00000}) + 26'({qy0_ff, 3'b000})
                + 26'({qy0_ff, 2'b00}) + 26'(qy0_ff);
      rem_y     = 26'(num_y_ff) - y_times45;
      qy        = 21'(qy0_ff) + 21'(rem_y >= 26'd45);
      pos_x_in  = (qx > 21'(mst_pkg::POS_MAX)) ? mst_pkg::POS_MAX : qx[18:0];
      pos_y_in  = (qy > 21'(mst_pkg::POS_MAX)) ? mst_pkg::POS_MAX : qy[18:0];
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   assign done  = done_ff;
   assign pos_x = pos_x_ff;
   assign pos_y = pos_y_ff;

endmodule

`default_nettype wire

### src/mst_cell.sv
// ----------------------------------------------------------------------------
// mst_cell: one contact slot
// Holds a slot's finger, position and marks. Takes part in three priority
// chains (finger hit, lowest free slot, lowest pending end) and hands the
// chain word on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mst_pkg::slot_idx_type cell_idx,
   input  wire mst_pkg::cell_cmd_type cmd,
   input  wire logic                  any_hit,
   input  wire mst_pkg::chain_type    chain_in,
   output mst_pkg::chain_type         chain_out
);

   logic                         active_ff, active_in;
   logic                         seen_ff, seen_in;
   logic                         pend_ff, pend_in;
   logic [mst_pkg::FINGER_W-1:0] finger_ff;
   mst_pkg::pos_type             x_ff, y_ff;
   logic                         match, hit_sel, free_sel, pend_sel;

   // Select this cell on each chain
   always_comb begin
      match    = active_ff && (finger_ff == cmd.finger);
      hit_sel  = cmd.report && match && !chain_in.hit;
      free_sel = cmd.report && !any_hit && !active_ff && !chain_in.free;
      pend_sel = cmd.walk && pend_ff && !chain_in.pend;
   end

   // Pass the chain word on, claiming it where this cell is first
   always_comb begin
      chain_out = chain_in;
      if (match && !chain_in.hit) begin
         chain_out.hit     = 1'b1;
         chain_out.hit_idx = cell_idx;
         chain_out.moved   = (x_ff != cmd.x) || (y_ff != cmd.y);
      end
      if (!active_ff && !chain_in.free) begin
         chain_out.free     = 1'b1;
         chain_out.free_idx = cell_idx;
      end
      if (pend_ff) begin
         if (chain_in.pend) begin
            chain_out.pend2 = 1'b1;
         end else begin
            chain_out.pend     = 1'b1;
            chain_out.pend_idx = cell_idx;
            chain_out.pend_x   = x_ff;
            chain_out.pend_y   = y_ff;
         end
      end
   end

   // Next slot marks
   always_comb begin
      active_in = active_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      if (free_sel) begin
         active_in = 1'b1;
      end else if (pend_sel) begin
         active_in = 1'b0;
      end
      if (cmd.eof_mark) begin
         seen_in = 1'b0;
         pend_in = active_ff && !seen_ff;
      end else begin
         if (hit_sel || free_sel) begin
            seen_in = 1'b1;
         end
         if (pend_sel) begin
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         seen_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
      end
   end

   // Hold finger and position; write on start or on a hit
   always_ff @(posedge clock) begin
      if (free_sel) begin
         finger_ff <= cmd.finger;
      end
      if (free_sel || hit_sel) begin
         x_ff <= cmd.x;
         y_ff <= cmd.y;
      end
   end

endmodule

`default_nettype wire

### src/multitouch_slot_tracker.sv
// ----------------------------------------------------------------------------
// multitouch_slot_tracker: contact slot tracker for up to eight touches
// Sequencer, scaler and a row of slot cells that turn contact reports into
// start, move and end events.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word is taken at a clock edge with start high and busy low.
//   req_mode 0 is a contact report (finger id, panel x/y), 1 is end of frame.
//   Results: each event word shows on the rsp_ ports for one cycle with
//   rsp_strobe high; rsp_last marks the final event of an input word. The
//   receiver cannot stall, so events are never held back.
//   Contact report: scaled through a three-stage multiplier pipeline, then
//   matched against all slots at once; the event (if any) is on the rsp_
//   ports after the scaler stages and the event register, and busy drops
//   with it. A new word is taken only after busy drops.
//   The ninth and later reports of a frame are dropped at once, busy stays low.
//   End of frame: marks unseen active slots as the word is taken, then walks
//   them one per cycle, lowest slot first, for up to 8 end events; when
//   nothing ends, no event word is given.
//   Registers: csr_index 0 render width, 1 render height; write only while
//   idle. Reset clears all slots and marks and loads 1280 x 720; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module multitouch_slot_tracker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_mode,
   input  wire logic [mst_pkg::FINGER_W-1:0]     req_finger_id,
   input  wire logic [mst_pkg::PANEL_X_W-1:0]    req_panel_x,
   input  wire logic [mst_pkg::PANEL_Y_W-1:0]    req_panel_y,
   output logic                                  rsp_strobe,
   output logic [mst_pkg::EVENT_W-1:0]           rsp_event_res,
   output logic [mst_pkg::RSP_SLOT_W-1:0]        rsp_slot,
   output logic [mst_pkg::POS_W-1:0]             rsp_pos_x,
   output logic [mst_pkg::POS_W-1:0]             rsp_pos_y,
   output logic                                  rsp_last,
   input  wire logic                             csr_we,
   input  wire logic                             csr_index,
   input  wire logic [mst_pkg::RENDER_W-1:0]     csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCALE = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [mst_pkg::RPT_CNT_W-1:0]   rpt_cnt_ff, rpt_cnt_in;
   logic [mst_pkg::RENDER_W-1:0]    render_w_ff, render_h_ff;
   logic [mst_pkg::FINGER_W-1:0]    finger_ff;
   logic                            accept, take_report, sc_go, sc_done;
   mst_pkg::pos_type                sc_x, sc_y;
   mst_pkg::cell_cmd_type           cmd;
   mst_pkg::chain_type              chain [mst_pkg::SLOT_COUNT+1];
   mst_pkg::chain_type              chain_end;

   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic [mst_pkg::EVENT_W-1:0]     rsp_event_ff, rsp_event_in;
   mst_pkg::rsp_slot_type           rsp_slot_ff, rsp_slot_in;
   mst_pkg::pos_type                rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                            rsp_last_ff, rsp_last_in;

   // Accept and qualify the input word
   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign take_report = accept && (req_mode == mst_pkg::MODE_REPORT)
                      && (rpt_cnt_ff < mst_pkg::MAX_REPORTS);
   assign sc_go       = take_report;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         render_w_ff <= mst_pkg::RENDER_WIDTH_RST;
         render_h_ff <= mst_pkg::RENDER_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            mst_pkg::CSR_RENDER_WIDTH:  render_w_ff <= csr_wdata;
            mst_pkg::CSR_RENDER_HEIGHT: render_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold the finger id of the report in flight
   always_ff @(posedge clock) begin
      if (take_report) begin
         finger_ff <= req_finger_id;
      end
   end

   mst_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .go       (sc_go),
      .panel_x  (req_panel_x),
      .panel_y  (req_panel_y),
      .render_w (render_w_ff),
      .render_h (render_h_ff),
      .done     (sc_done),
      .pos_x    (sc_x),
      .pos_y    (sc_y)
   );

   // Broadcast to the slot row
   always_comb begin
      cmd.report   = (state_ff == ST_SCALE) && sc_done;
      cmd.eof_mark = accept && (req_mode == mst_pkg::MODE_EOF);
      cmd.walk     = (state_ff == ST_WALK);
      cmd.finger   = finger_ff;
      cmd.x        = sc_x;
      cmd.y        = sc_y;
   end

   assign chain[0] = '0;

   for (genvar i = 0; i < mst_pkg::SLOT_COUNT; i++) begin : g_cell
      mst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (mst_pkg::slot_idx_type'(i)),
         .cmd       (cmd),
         .any_hit   (chain_end.hit),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   assign chain_end = chain[mst_pkg::SLOT_COUNT];

   // Sequence the word and build the event word
   always_comb begin
      state_in      = state_ff;
      rpt_cnt_in    = rpt_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_event_in  = rsp_event_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.eof_mark) begin
               rpt_cnt_in = '0;
               state_in   = ST_WALK;
            end else if (take_report) begin
               rpt_cnt_in = rpt_cnt_ff + 1'b1;
               state_in   = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (sc_done) begin
               state_in    = ST_IDLE;
               rsp_x_in    = sc_x;
               rsp_y_in    = sc_y;
               rsp_last_in = 1'b1;
               if (chain_end.hit) begin
                  rsp_strobe_in = chain_end.moved;
                  rsp_event_in  = mst_pkg::EV_MOVE;
                  rsp_slot_in   = mst_pkg::rsp_slot_type'(chain_end.hit_idx);
               end else if (chain_end.free) begin
                  rsp_strobe_in = 1'b1;
                  rsp_event_in  = mst_pkg::EV_START;
                  rsp_slot_in   = mst_pkg::rsp_slot_type'(chain_end.free_idx);
               end
            end
         end
         ST_WALK: begin
            if (chain_end.pend) begin
               rsp_strobe_in = 1'b1;
               rsp_event_in  = mst_pkg::EV_END;
               rsp_slot_in   = mst_pkg::rsp_slot_type'(chain_end.pend_idx);
               rsp_x_in      = chain_end.pend_x;
               rsp_y_in      = chain_end.pend_y;
               rsp_last_in   = !chain_end.pend2;
               if (!chain_end.pend2) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rpt_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rpt_cnt_ff    <= rpt_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_pos_x     = rsp_x_ff;
   assign rsp_pos_y     = rsp_y_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // An event word only follows work in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("event word without work in progress");

   // The final event of a word leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> state_ff == ST_IDLE)
      else $error("sequencer not idle after final event");

   // Events of one word come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside an end-of-frame burst");

   // End events come only from the walk
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_event_res == mst_pkg::EV_END |-> $past(state_ff == ST_WALK))
      else $error("end event outside the walk");

   // Report count stays within the frame limit
   assert property (@(posedge clock) disable iff (reset)
      rpt_cnt_ff <= mst_pkg::MAX_REPORTS)
      else $error("report count beyond frame limit");
`endif

endmodule

`default_nettype wire
